// ===== sv/sorted_topk_insert_macros.svh =====
// Assertion macros used by the sorted top-k table top level.
`ifndef SORTED_TOPK_INSERT_MACROS_SVH
`define SORTED_TOPK_INSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and held off during rst.
`define STKI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and held off during rst.
`define STKI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/stki_pkg.sv =====
// Types and constants of the sorted top-k table.
`default_nettype none

package stki_pkg;

  localparam int SCORE_W = 32;
  localparam int TAG_W   = 16;
  localparam int RANK_W  = 4;
  localparam int COUNT_W = 5;
  localparam int CAP_W   = 5;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd10;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  typedef struct packed {
    logic                      action;
    logic signed [SCORE_W-1:0] new_score;
    logic [TAG_W-1:0]          entry_tag;
    logic [RANK_W-1:0]         read_rank;
  } in_t;

  typedef struct packed {
    logic                      accepted;
    logic [RANK_W-1:0]         placed_rank;
    logic [COUNT_W-1:0]        entry_count;
    logic                      read_valid;
    logic signed [SCORE_W-1:0] read_score;
    logic [TAG_W-1:0]          read_tag;
  } out_t;

  // Per-cell controls decoded at the top level for one insert request.
  typedef struct packed {
    logic ins;     // insert request is being applied this cycle
    logic cmp_ok;  // cell lies above the last rank of the new table
    logic in_win;  // cell lies inside the new table
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== sv/stki_cell.sv =====
// One rank of the sorted table: holds an entry and shifts it down on insert.
`default_nettype none

module stki_cell #(
  parameter int TW = 16
) (
  input  wire                                   clk,
  input  wire stki_pkg::cell_ctl_t              ctl,
  input  wire logic signed [stki_pkg::SCORE_W-1:0] new_score,
  input  wire logic [TW-1:0]                    new_tag,
  input  wire logic signed [stki_pkg::SCORE_W-1:0] up_score,
  input  wire logic [TW-1:0]                    up_tag,
  input  wire logic                             up_ge,
  output logic signed [stki_pkg::SCORE_W-1:0]   score,
  output logic [TW-1:0]                         tag,
  output logic                                  ge,
  output logic                                  gt_raw,
  output logic                                  land
);

  logic move;

  // Entries >= the new score stay, bar the last rank; the first below takes it.
  assign ge     = ctl.cmp_ok && (score >= new_score);
  assign gt_raw = score > new_score;
  assign land   = ctl.in_win && !ge && up_ge;
  assign move   = ctl.in_win && !ge && !up_ge;

  always_ff @(posedge clk) begin
    if (ctl.ins && land) begin
      score <= new_score;
      tag   <= new_tag;
    end else if (ctl.ins && move) begin
      score <= up_score;
      tag   <= up_tag;
    end
  end

endmodule

`default_nettype wire

// ===== sv/sorted_topk_insert.sv =====
// Sorted top-k table: one request per clock, one result in the cycle after it.
// Latency: the result strobe done rises in the cycle after start is taken.
// Throughput: one request every cycle; busy is never raised, and every cell
// compares and shifts in parallel in the same cycle as its neighbors.
// Reset: entry count clears to zero, capacity returns to 10, done clears.
// Stored entries are not cleared; only ranks below the count are ever read.
`default_nettype none

module sorted_topk_insert #(
  parameter int MAX_ENTRIES = 16,
  parameter int TAG_BITS    = 16
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              start,
  output logic                             busy,
  input  wire stki_pkg::in_t               req,
  output logic                             done,
  output stki_pkg::out_t                   rsp,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [stki_pkg::CAP_W-1:0]  cfg_data
);

  `include "sorted_topk_insert_macros.svh"

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int EW = (CW > stki_pkg::CAP_W) ? CW : stki_pkg::CAP_W;
  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int RW = (IW > stki_pkg::RANK_W) ? IW : stki_pkg::RANK_W;
  localparam int KW = (TAG_BITS < stki_pkg::TAG_W) ? TAG_BITS : stki_pkg::TAG_W;

  logic [stki_pkg::CAP_W-1:0] capacity;
  logic [CW-1:0]              count;
  logic [CW-1:0]              count_next;

  logic [EW-1:0] cap_eff;
  logic [EW-1:0] cfg_cap_eff;
  logic [EW-1:0] count_x;
  logic [EW-1:0] n;
  logic          full;
  logic          reject;
  logic          take;
  logic          accept;
  logic          is_ins;

  logic signed [stki_pkg::SCORE_W-1:0] score_q [MAX_ENTRIES];
  logic [KW-1:0]                       tag_q   [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]              ge;
  logic [MAX_ENTRIES-1:0]              gt_raw;
  logic [MAX_ENTRIES-1:0]              land;
  logic [MAX_ENTRIES-1:0]              is_last;
  stki_pkg::cell_ctl_t                 ctl [MAX_ENTRIES];

  logic [IW-1:0]  pos;
  logic [RW-1:0]  pos_w;
  logic [RW-1:0]  rank_w;
  logic           rd_ok;
  logic [KW-1:0]  new_tag;
  stki_pkg::out_t rsp_next;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign is_ins    = (req.action == stki_pkg::ACT_INSERT);
  assign new_tag   = req.entry_tag[KW-1:0];
  assign count_x   = EW'(count);

  // Capacity of zero acts as one; above the table size it saturates.
  always_comb begin
    if (capacity == '0) begin
      cap_eff = EW'(1);
    end else if (EW'(capacity) > EW'(MAX_ENTRIES)) begin
      cap_eff = EW'(MAX_ENTRIES);
    end else begin
      cap_eff = EW'(capacity);
    end
    if (cfg_data == '0) begin
      cfg_cap_eff = EW'(1);
    end else if (EW'(cfg_data) > EW'(MAX_ENTRIES)) begin
      cfg_cap_eff = EW'(MAX_ENTRIES);
    end else begin
      cfg_cap_eff = EW'(cfg_data);
    end
  end

  assign full = count_x >= cap_eff;
  assign n    = full ? cap_eff : count_x + EW'(1);

  // A full table turns away a score strictly below its last entry.
  assign reject = full && ((gt_raw & is_last) != '0);
  assign take   = !reject;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    assign is_last[i]    = (EW'(i + 1) == cap_eff);
    assign ctl[i].ins    = accept && is_ins && take;
    assign ctl[i].in_win = EW'(i) < n;
    assign ctl[i].cmp_ok = EW'(i + 1) < n;

    if (i == 0) begin : g_head
      stki_cell #(.TW(KW)) u_cell (
        .clk      (clk),
        .ctl      (ctl[i]),
        .new_score(req.new_score),
        .new_tag  (new_tag),
        .up_score (req.new_score),
        .up_tag   (new_tag),
        .up_ge    (1'b1),
        .score    (score_q[i]),
        .tag      (tag_q[i]),
        .ge       (ge[i]),
        .gt_raw   (gt_raw[i]),
        .land     (land[i])
      );
    end else begin : g_body
      stki_cell #(.TW(KW)) u_cell (
        .clk      (clk),
        .ctl      (ctl[i]),
        .new_score(req.new_score),
        .new_tag  (new_tag),
        .up_score (score_q[i-1]),
        .up_tag   (tag_q[i-1]),
        .up_ge    (ge[i-1]),
        .score    (score_q[i]),
        .tag      (tag_q[i]),
        .ge       (ge[i]),
        .gt_raw   (gt_raw[i]),
        .land     (land[i])
      );
    end
  end

  // Exactly one cell lands the new entry; encode its rank.
  always_comb begin
    pos = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (land[i]) begin
        pos = pos | IW'(i);
      end
    end
  end

  assign pos_w  = RW'(pos);
  assign rank_w = RW'(req.read_rank);
  assign rd_ok  = (EW'(req.read_rank) < count_x) &&
                  ({{(32 - stki_pkg::RANK_W){1'b0}}, req.read_rank} < 32'(MAX_ENTRIES));

  always_comb begin
    count_next = count;
    if (cfg_valid && cfg_ready && count_x > cfg_cap_eff) begin
      count_next = CW'(cfg_cap_eff);
    end else if (accept && is_ins && take) begin
      count_next = CW'(n);
    end
  end

  always_comb begin
    rsp_next             = '0;
    rsp_next.entry_count = stki_pkg::COUNT_W'(EW'(count_next));
    if (is_ins) begin
      if (take) begin
        rsp_next.accepted    = 1'b1;
        rsp_next.placed_rank = pos_w[stki_pkg::RANK_W-1:0];
      end
    end else if (rd_ok) begin
      rsp_next.read_valid = 1'b1;
      rsp_next.read_score = score_q[rank_w[IW-1:0]];
      rsp_next.read_tag   = stki_pkg::TAG_W'(tag_q[rank_w[IW-1:0]]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= stki_pkg::CAPACITY_RESET;
      count    <= '0;
      done     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      count <= count_next;
      done  <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  `STKI_ASSERT_NEXT(a_done_follows_request, accept, done, "request without a result strobe")
  `STKI_ASSERT_NOW(a_count_within_capacity, 1'b1, count_x <= cap_eff, "count above capacity")
  `STKI_ASSERT_NOW(a_single_landing, accept && is_ins && take, $onehot(land), "landing not unique")
  `STKI_ASSERT_NOW(a_result_kind, done, !(rsp.accepted && rsp.read_valid), "insert and read mixed")

endmodule

`default_nettype wire
